>>> src/sau_pkg.sv
// ----------------------------------------------------------------------------
// sau_pkg: shared types and constants of the small-alphabet unpack decoder
// Holds the channel types, the work item that passes from the front to the
// back, and the format codes of the stream header.
// ----------------------------------------------------------------------------
package sau_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int LEN_BITS_DEF    = 32;
	localparam int TBL_IDX_W       = 4;
	localparam int REP_W           = 32;
	localparam int WQ_DEPTH        = 2;
	localparam int OUT_DEPTH       = 4;
	localparam int OUT_LVL_W       = $clog2(OUT_DEPTH + 1);
	localparam int LEN_CONT_BIT    = 7;

	localparam logic [7:0] FMT_CODE_RUN   = 8'h00;
	localparam logic [7:0] FMT_CODE_RAW   = 8'h01;
	localparam logic [7:0] FMT_CODE_TWO   = 8'h02;
	localparam logic [7:0] FMT_CODE_FOUR  = 8'h04;
	localparam logic [7:0] FMT_CODE_EIGHT = 8'h08;

	typedef enum logic [2:0] {
		PH_FORMAT,
		PH_RAW,
		PH_TABLE_FIRST,
		PH_TABLE,
		PH_LENGTH,
		PH_DATA,
		PH_DRAIN
	} phase_t;

	typedef enum logic [1:0] {
		FM_RUN,
		FM_TWO,
		FM_FOUR,
		FM_EIGHT
	} fmt_mode_t;

	typedef enum logic [2:0] {
		WK_CLEAR,
		WK_WRITE,
		WK_EMIT,
		WK_RUN,
		WK_UNPACK
	} work_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       symbol;
		logic [REP_W-1:0] repeat_count;
		logic             last;
		logic             error;
	} result_t;

	typedef struct packed {
		work_kind_t           kind;
		logic [7:0]           data;
		logic [REP_W-1:0]     rep;
		logic                 last;
		logic                 err;
		fmt_mode_t            mode;
		logic [3:0]           count;
		logic [TBL_IDX_W-1:0] addr;
	} work_item_t;

endpackage

>>> src/sau_fifo.sv
// ----------------------------------------------------------------------------
// sau_fifo: small register queue
// First-in first-out buffer with a fill level, used between the front and
// the back and again on the result side.
// ----------------------------------------------------------------------------
module sau_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	output logic                           full,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign level   = count_q;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/sau_front.sv
// ----------------------------------------------------------------------------
// sau_front: stream parser
// Follows the header, table and length fields of the stream one byte at a
// time and turns each byte into at most one work item for the back.
// ----------------------------------------------------------------------------
module sau_front #(
	parameter int TABLE_DEPTH = sau_pkg::TABLE_DEPTH_DEF,
	parameter int LEN_BITS    = sau_pkg::LEN_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sau_pkg::in_item_t    item,
	output logic                 full,
	output logic                 wq_push,
	output sau_pkg::work_item_t  wq_item,
	input  logic                 wq_full
);

	localparam int SHW = $clog2(LEN_BITS + 1);
	localparam int FW  = $clog2(TABLE_DEPTH + 1);
	localparam int EW  = LEN_BITS + 7;
	localparam int IW  = sau_pkg::TBL_IDX_W;
	localparam int RW  = sau_pkg::REP_W;

	sau_pkg::phase_t    phase_q;
	sau_pkg::phase_t    phase_d;
	sau_pkg::fmt_mode_t mode_q;
	sau_pkg::fmt_mode_t fmt_mode;
	logic [FW-1:0]       fill_q;
	logic [LEN_BITS-1:0] accum_q;
	logic [SHW-1:0]      shift_q;
	logic [LEN_BITS-1:0] left_q;

	logic                accept;
	logic [7:0]          b;
	logic                eos;
	logic                fmt_ok;
	logic [EW-1:0]       shifted;
	logic                ovf;
	logic [LEN_BITS-1:0] len_new;
	logic [SHW:0]        shift_inc;
	logic [SHW-1:0]      shift_sat;
	logic [3:0]          per;
	logic                left_gt;
	logic [3:0]          n_sym;
	logic [LEN_BITS-1:0] left_new;
	logic                tbl_wr;

	assign full   = wq_full;
	assign accept = push && !wq_full;
	assign b      = item.data_byte;
	assign eos    = item.end_of_stream;

	always_comb begin
		fmt_ok   = 1'b1;
		fmt_mode = sau_pkg::FM_RUN;
		unique case (b)
			sau_pkg::FMT_CODE_RUN:   fmt_mode = sau_pkg::FM_RUN;
			sau_pkg::FMT_CODE_TWO:   fmt_mode = sau_pkg::FM_TWO;
			sau_pkg::FMT_CODE_FOUR:  fmt_mode = sau_pkg::FM_FOUR;
			sau_pkg::FMT_CODE_EIGHT: fmt_mode = sau_pkg::FM_EIGHT;
			default:                 fmt_ok   = 1'b0;
		endcase
	end

	// Length varint: place seven payload bits at the current shift and
	// flag any bit that lands at or above LEN_BITS.
	assign shifted   = EW'(b[6:0]) << shift_q;
	assign ovf       = (shift_q >= SHW'(LEN_BITS)) ? (b[6:0] != 7'd0)
	                                               : (|shifted[EW-1:LEN_BITS]);
	assign len_new   = accum_q | shifted[LEN_BITS-1:0];
	assign shift_inc = {1'b0, shift_q} + (SHW+1)'(7);
	assign shift_sat = (shift_inc > (SHW+1)'(LEN_BITS)) ? SHW'(LEN_BITS)
	                                                   : shift_inc[SHW-1:0];

	always_comb begin
		unique case (mode_q)
			sau_pkg::FM_EIGHT: per = 4'd8;
			sau_pkg::FM_FOUR:  per = 4'd4;
			default:           per = 4'd2;
		endcase
	end

	assign left_gt  = left_q > LEN_BITS'(per);
	assign n_sym    = left_gt ? per : left_q[3:0];
	assign left_new = left_q - LEN_BITS'(n_sym);
	assign tbl_wr   = !eos && (fill_q < FW'(TABLE_DEPTH)) &&
	                  ((phase_q == sau_pkg::PH_TABLE_FIRST) || (b != 8'd0));

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			sau_pkg::PH_FORMAT: begin
				if (b == sau_pkg::FMT_CODE_RAW) begin
					phase_d = eos ? sau_pkg::PH_FORMAT : sau_pkg::PH_RAW;
				end else if (fmt_ok && !eos) begin
					phase_d = sau_pkg::PH_TABLE_FIRST;
				end else begin
					phase_d = eos ? sau_pkg::PH_FORMAT : sau_pkg::PH_DRAIN;
				end
			end
			sau_pkg::PH_RAW: begin
				phase_d = eos ? sau_pkg::PH_FORMAT : sau_pkg::PH_RAW;
			end
			sau_pkg::PH_TABLE_FIRST: begin
				phase_d = eos ? sau_pkg::PH_FORMAT : sau_pkg::PH_TABLE;
			end
			sau_pkg::PH_TABLE: begin
				if (eos) begin
					phase_d = sau_pkg::PH_FORMAT;
				end else if (b == 8'd0) begin
					phase_d = sau_pkg::PH_LENGTH;
				end
			end
			sau_pkg::PH_LENGTH: begin
				if (eos) begin
					phase_d = sau_pkg::PH_FORMAT;
				end else if (ovf) begin
					phase_d = sau_pkg::PH_DRAIN;
				end else if (b[sau_pkg::LEN_CONT_BIT]) begin
					phase_d = sau_pkg::PH_LENGTH;
				end else if ((len_new == '0) || (mode_q == sau_pkg::FM_RUN)) begin
					phase_d = sau_pkg::PH_DRAIN;
				end else begin
					phase_d = sau_pkg::PH_DATA;
				end
			end
			sau_pkg::PH_DATA: begin
				if (eos) begin
					phase_d = sau_pkg::PH_FORMAT;
				end else if (left_new == '0) begin
					phase_d = sau_pkg::PH_DRAIN;
				end
			end
			sau_pkg::PH_DRAIN: begin
				phase_d = eos ? sau_pkg::PH_FORMAT : sau_pkg::PH_DRAIN;
			end
			default: phase_d = sau_pkg::PH_FORMAT;
		endcase
	end

	// Work item for the back.
	always_comb begin
		wq_push         = 1'b0;
		wq_item.kind    = sau_pkg::WK_EMIT;
		wq_item.data    = 8'd0;
		wq_item.rep     = '0;
		wq_item.last    = 1'b1;
		wq_item.err     = 1'b1;
		wq_item.mode    = mode_q;
		wq_item.count   = n_sym;
		wq_item.addr    = IW'(fill_q);
		unique case (phase_q)
			sau_pkg::PH_FORMAT: begin
				if (b != sau_pkg::FMT_CODE_RAW) begin
					wq_push = 1'b1;
					if (fmt_ok && !eos) begin
						wq_item.kind = sau_pkg::WK_CLEAR;
					end
				end
			end
			sau_pkg::PH_RAW: begin
				wq_push      = 1'b1;
				wq_item.data = b;
				wq_item.rep  = RW'(1);
				wq_item.last = eos;
				wq_item.err  = 1'b0;
			end
			sau_pkg::PH_TABLE_FIRST, sau_pkg::PH_TABLE: begin
				if (eos) begin
					wq_push = 1'b1;
				end else if (tbl_wr) begin
					wq_push      = 1'b1;
					wq_item.kind = sau_pkg::WK_WRITE;
					wq_item.data = b;
				end
			end
			sau_pkg::PH_LENGTH: begin
				if (ovf || (b[sau_pkg::LEN_CONT_BIT] && eos)) begin
					wq_push = 1'b1;
				end else if (!b[sau_pkg::LEN_CONT_BIT] && (len_new != '0)) begin
					if (mode_q == sau_pkg::FM_RUN) begin
						wq_push      = 1'b1;
						wq_item.kind = sau_pkg::WK_RUN;
						wq_item.rep  = RW'(len_new);
						wq_item.err  = 1'b0;
					end else if (eos) begin
						wq_push = 1'b1;
					end
				end
			end
			sau_pkg::PH_DATA: begin
				wq_push = 1'b1;
				if (!(eos && left_gt)) begin
					wq_item.kind = sau_pkg::WK_UNPACK;
					wq_item.data = b;
					wq_item.last = (left_new == '0);
					wq_item.err  = 1'b0;
				end
			end
			default: wq_push = 1'b0;
		endcase
		wq_push = wq_push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sau_pkg::PH_FORMAT;
			mode_q  <= sau_pkg::FM_RUN;
			fill_q  <= '0;
			accum_q <= '0;
			shift_q <= '0;
			left_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			case (phase_q) inside
				sau_pkg::PH_FORMAT: begin
					fill_q  <= '0;
					accum_q <= '0;
					shift_q <= '0;
					left_q  <= '0;
					if (fmt_ok) begin
						mode_q <= fmt_mode;
					end
				end
				sau_pkg::PH_TABLE_FIRST, sau_pkg::PH_TABLE: begin
					if (tbl_wr) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				sau_pkg::PH_LENGTH: begin
					if (!ovf) begin
						accum_q <= len_new;
					end
					if (b[sau_pkg::LEN_CONT_BIT]) begin
						shift_q <= shift_sat;
					end else begin
						left_q <= len_new;
					end
				end
				sau_pkg::PH_DATA: begin
					left_q <= left_new;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> src/sau_back.sv
// ----------------------------------------------------------------------------
// sau_back: table store and symbol unpacker
// Executes work items: clears and fills the symbol table, and emits one
// result per cycle while it has credit, unpacking bytes symbol by symbol.
// ----------------------------------------------------------------------------
module sau_back #(
	parameter int TABLE_DEPTH = sau_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sau_pkg::work_item_t           wq_item,
	input  logic                          wq_empty,
	output logic                          wq_pop,
	input  logic [sau_pkg::OUT_LVL_W-1:0] out_level,
	output logic                          out_push,
	output sau_pkg::result_t              out_result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IW = sau_pkg::TBL_IDX_W;
	localparam int RW = sau_pkg::REP_W;
	localparam int LW = sau_pkg::OUT_LVL_W;

	logic [7:0]         mem_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;

	logic               busy_q;
	logic [7:0]         cur_byte_q;
	sau_pkg::fmt_mode_t cur_mode_q;
	logic [3:0]         cur_cnt_q;
	logic               cur_last_q;

	logic               valid_s2;
	logic               use_tbl_s2;
	logic               hit_s2;
	logic [7:0]         sym_s2;
	logic [7:0]         rd_data_s2;
	logic [RW-1:0]      rep_s2;
	logic               last_s2;
	logic               err_s2;

	logic               credit;
	logic [7:0]         src_byte;
	sau_pkg::fmt_mode_t src_mode;
	logic [3:0]         src_cnt;
	logic               src_last;
	logic [IW-1:0]      unp_idx;
	logic [7:0]         unp_rest;

	logic               issue;
	logic               tbl_clr;
	logic               tbl_wr;
	logic               load;
	logic               use_tbl_s1;
	logic [IW-1:0]      idx_s1;
	logic [7:0]         sym_s1;
	logic [RW-1:0]      rep_s1;
	logic               last_s1;
	logic               err_s1;
	logic [AW-1:0]      rd_addr;
	logic               hit_s1;

	// A slot is reserved in the result queue for the result now in stage 2.
	assign credit = (({1'b0, out_level} + (LW+1)'(valid_s2)) < (LW+1)'(sau_pkg::OUT_DEPTH));

	assign src_byte = busy_q ? cur_byte_q : wq_item.data;
	assign src_mode = busy_q ? cur_mode_q : wq_item.mode;
	assign src_cnt  = busy_q ? cur_cnt_q  : wq_item.count;
	assign src_last = busy_q ? cur_last_q : wq_item.last;

	// The most significant index of the byte comes out first.
	always_comb begin
		unique case (src_mode)
			sau_pkg::FM_EIGHT: begin
				unp_idx  = IW'(src_byte[7]);
				unp_rest = {src_byte[6:0], 1'b0};
			end
			sau_pkg::FM_FOUR: begin
				unp_idx  = IW'(src_byte[7:6]);
				unp_rest = {src_byte[5:0], 2'b0};
			end
			default: begin
				unp_idx  = IW'(src_byte[7:4]);
				unp_rest = {src_byte[3:0], 4'b0};
			end
		endcase
	end

	always_comb begin
		issue      = 1'b0;
		wq_pop     = 1'b0;
		tbl_clr    = 1'b0;
		tbl_wr     = 1'b0;
		load       = 1'b0;
		use_tbl_s1 = 1'b1;
		idx_s1     = unp_idx;
		sym_s1     = wq_item.data;
		rep_s1     = RW'(1);
		last_s1    = src_last && (src_cnt == 4'd1);
		err_s1     = 1'b0;
		if (busy_q) begin
			issue = credit;
		end else if (!wq_empty) begin
			unique case (wq_item.kind)
				sau_pkg::WK_CLEAR: begin
					tbl_clr = 1'b1;
					wq_pop  = 1'b1;
				end
				sau_pkg::WK_WRITE: begin
					tbl_wr = 1'b1;
					wq_pop = 1'b1;
				end
				sau_pkg::WK_EMIT: begin
					issue      = credit;
					wq_pop     = credit;
					use_tbl_s1 = 1'b0;
					rep_s1     = wq_item.rep;
					last_s1    = wq_item.last;
					err_s1     = wq_item.err;
				end
				sau_pkg::WK_RUN: begin
					issue   = credit;
					wq_pop  = credit;
					idx_s1  = '0;
					rep_s1  = wq_item.rep;
					last_s1 = 1'b1;
				end
				sau_pkg::WK_UNPACK: begin
					issue  = credit;
					wq_pop = credit;
					load   = credit && (wq_item.count > 4'd1);
				end
				default: wq_pop = 1'b1;
			endcase
		end
	end

	assign rd_addr = idx_s1[AW-1:0];
	assign hit_s1  = ({1'b0, idx_s1} < (IW+1)'(TABLE_DEPTH)) && vld_q[rd_addr];

	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			mem_q[wq_item.addr[AW-1:0]] <= wq_item.data;
		end
		rd_data_s2 <= mem_q[rd_addr];
		use_tbl_s2 <= use_tbl_s1;
		hit_s2     <= hit_s1;
		sym_s2     <= sym_s1;
		rep_s2     <= rep_s1;
		last_s2    <= last_s1;
		err_s2     <= err_s1;
		if (issue) begin
			cur_byte_q <= unp_rest;
			cur_cnt_q  <= src_cnt - 1'b1;
		end
		if (load) begin
			cur_mode_q <= wq_item.mode;
			cur_last_q <= wq_item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			vld_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= issue;
			if (tbl_clr) begin
				vld_q <= '0;
			end else if (tbl_wr) begin
				vld_q[wq_item.addr[AW-1:0]] <= 1'b1;
			end
			if (load) begin
				busy_q <= 1'b1;
			end else if (busy_q && issue && (cur_cnt_q == 4'd1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign out_push                = valid_s2;
	assign out_result.symbol       = use_tbl_s2 ? (hit_s2 ? rd_data_s2 : 8'd0) : sym_s2;
	assign out_result.repeat_count = rep_s2;
	assign out_result.last         = last_s2;
	assign out_result.error        = err_s2;

endmodule

>>> src/small_alphabet_unpack_decoder_unit.sv
// ----------------------------------------------------------------------------
// small_alphabet_unpack_decoder_unit: packed small-alphabet stream decoder
// Decodes a byte stream with a format byte, a symbol table, a varint length
// and packed table indices into symbol results, with raw and run formats.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// item      in         push / full  (push & !full)  data_byte, end_of_stream
// result    out        pop / empty  (pop & !empty)  symbol, repeat_count, last, error
//
// A packed data byte yields up to two, four or eight symbols. The back-end
// unpacker takes no new work item until the byte is done, and produces one
// result per cycle while the result queue has room. A result passes from
// the edge that accepts its byte through the work queue, the stage 2
// registers and the result queue to the result ports, and can then be popped.
// Reset is asynchronous and needs no clearing pass; the table valid bits
// clear at once. A stalled result side fills the result queue, then the
// work queue, and only then raises full.
//
module small_alphabet_unpack_decoder_unit #(
	parameter int TABLE_DEPTH = sau_pkg::TABLE_DEPTH_DEF,
	parameter int LEN_BITS    = sau_pkg::LEN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sau_pkg::in_item_t item,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output sau_pkg::result_t  result
);

	// The front end parses the stream and hands at most one work item per
	// byte to the back end through a short queue. Each work item is one
	// transaction on that queue. The queue keeps table writes and table reads
	// in stream order, so a new stream can start while the old one is still
	// unpacking.
	logic                          wq_push;
	logic                          wq_full;
	logic                          wq_pop;
	logic                          wq_empty;
	sau_pkg::work_item_t           wq_in;
	sau_pkg::work_item_t           wq_head;

	// The back end writes finished results into the result queue, which
	// presents the oldest one on the result ports.
	logic                          out_push;
	logic                          out_full;
	logic [sau_pkg::OUT_LVL_W-1:0] out_level;
	sau_pkg::result_t              out_result;

	sau_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.LEN_BITS    (LEN_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.wq_push (wq_push),
		.wq_item (wq_in),
		.wq_full (wq_full)
	);

	sau_fifo #(
		.WIDTH ($bits(sau_pkg::work_item_t)),
		.DEPTH (sau_pkg::WQ_DEPTH)
	) u_work_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (wq_push),
		.wdata  (wq_in),
		.full   (wq_full),
		.pop    (wq_pop),
		.rdata  (wq_head),
		.empty  (wq_empty),
		.level  ()
	);

	sau_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wq_item    (wq_head),
		.wq_empty   (wq_empty),
		.wq_pop     (wq_pop),
		.out_level  (out_level),
		.out_push   (out_push),
		.out_result (out_result)
	);

	sau_fifo #(
		.WIDTH ($bits(sau_pkg::result_t)),
		.DEPTH (sau_pkg::OUT_DEPTH)
	) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_result),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.level  (out_level)
	);

`ifndef ASSERT_OFF
	// The front end must never push a work item the queue cannot take.
	a_wq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wq_push |-> !wq_full)
		else $error("work item pushed into a full work queue");

	// The credit check in the back end must keep the result queue from
	// overflowing.
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into a full result queue");

	// An error result always ends its stream and carries no symbol.
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.error) |->
			(result.last && (result.symbol == 8'd0) && (result.repeat_count == '0)))
		else $error("malformed error result");
`endif

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the small-alphabet unpack decoder
// Feeds packed byte streams (raw, run and 2/4/8 per byte formats, plus broken
// and noisy streams) through the item queue and checks every result
// transaction against a cycle-free software decoder kept in this module.
// ----------------------------------------------------------------------------
module tb;
	import sau_pkg::*;

	localparam int TBL_DEPTH     = TABLE_DEPTH_DEF;
	localparam int LEN_LIMIT     = LEN_BITS_DEF;
	localparam int LEN_GROUP     = 7;
	localparam int RANDOM_ITEMS  = 480;
	localparam int IDLE_LIMIT    = 1000;
	localparam int SETTLE_CYCLES = 30;
	localparam int MAX_REPORTS   = 40;

	typedef logic [7:0] byte_q_t[$];

	// Receiver stall styles; each one holds for a random stretch of cycles.
	typedef enum logic [1:0] {
		POP_ALWAYS,
		POP_HALF,
		POP_SPARSE,
		POP_BURSTY
	} pop_style_t;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     push = 1'b0;
	logic     pop = 1'b0;
	in_item_t item = '0;
	logic     full;
	logic     empty;
	result_t  result;

	// Software copy of the decoder state, advanced once per accepted byte.
	phase_t      dec_phase;
	fmt_mode_t   dec_mode;
	logic [7:0]  dec_table [TBL_DEPTH];
	int          dec_fill;
	logic [63:0] dec_len;
	int          dec_shift;
	logic [63:0] dec_remaining;

	// Results the decoder still owes, oldest first.
	result_t expected_symbols[$];

	int mismatch_count = 0;
	int report_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	pop_style_t pop_style = POP_ALWAYS;
	int         style_left = 0;
	int         stall_left = 0;

	small_alphabet_unpack_decoder_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------------

	function automatic void emit(input logic [7:0] sym, input logic [31:0] rep,
			input logic is_last, input logic is_err);
		result_t r;
		r.symbol       = sym;
		r.repeat_count = rep;
		r.last         = is_last;
		r.error        = is_err;
		expected_symbols.push_back(r);
	endfunction

	// An error result always closes the stream. Without end of stream the
	// decoder throws away bytes until the stream ends.
	function automatic void flag_error(input logic eos);
		emit(8'h00, 32'd0, 1'b1, 1'b1);
		dec_phase = eos ? PH_FORMAT : PH_DRAIN;
	endfunction

	function automatic void decode_byte(input in_item_t it);
		logic [7:0]  b;
		logic        eos;
		logic [63:0] payload;
		int          room;
		int          per;
		int          bits;
		int          mask;
		int          idx;
		int          i;
		b   = it.data_byte;
		eos = it.end_of_stream;
		case (dec_phase)
			PH_FORMAT: begin
				// A format byte always wipes the table, so unwritten entries
				// read back as zero.
				for (i = 0; i < TBL_DEPTH; i++) dec_table[i] = 8'h00;
				dec_fill      = 0;
				dec_len       = '0;
				dec_shift     = 0;
				dec_remaining = '0;
				if (b == FMT_CODE_RAW) begin
					dec_phase = eos ? PH_FORMAT : PH_RAW;
					return;
				end
				if (b == FMT_CODE_RUN) dec_mode = FM_RUN;
				else if (b == FMT_CODE_TWO) dec_mode = FM_TWO;
				else if (b == FMT_CODE_FOUR) dec_mode = FM_FOUR;
				else if (b == FMT_CODE_EIGHT) dec_mode = FM_EIGHT;
				else begin
					flag_error(eos);
					return;
				end
				if (eos) flag_error(eos);
				else dec_phase = PH_TABLE_FIRST;
			end
			PH_RAW: begin
				emit(b, 32'd1, eos, 1'b0);
				if (eos) dec_phase = PH_FORMAT;
			end
			PH_TABLE_FIRST, PH_TABLE: begin
				// The first table byte is stored even when it is zero.
				if (dec_phase == PH_TABLE && b == 8'h00) begin
					dec_phase = PH_LENGTH;
				end else begin
					if (dec_fill < TBL_DEPTH) begin
						dec_table[dec_fill] = b;
						dec_fill++;
					end
					dec_phase = PH_TABLE;
				end
				if (eos) flag_error(eos);
			end
			PH_LENGTH: begin
				payload = {57'd0, b[6:0]};
				if (dec_shift >= LEN_LIMIT) begin
					if (payload != 0) begin
						flag_error(eos);
						return;
					end
				end else begin
					room = LEN_LIMIT - dec_shift;
					if (room < LEN_GROUP && (payload >> room) != 0) begin
						flag_error(eos);
						return;
					end
					dec_len |= payload << dec_shift;
				end
				if (b[LEN_CONT_BIT]) begin
					dec_shift += LEN_GROUP;
					if (dec_shift > LEN_LIMIT) dec_shift = LEN_LIMIT;
					if (eos) flag_error(eos);
					return;
				end
				dec_remaining = dec_len;
				if (dec_remaining == 0) begin
					dec_phase = eos ? PH_FORMAT : PH_DRAIN;
					return;
				end
				if (dec_mode == FM_RUN) begin
					emit(dec_table[0], dec_len[31:0], 1'b1, 1'b0);
					dec_remaining = '0;
					dec_phase = eos ? PH_FORMAT : PH_DRAIN;
					return;
				end
				if (eos) flag_error(eos);
				else dec_phase = PH_DATA;
			end
			PH_DATA: begin
				case (dec_mode)
					FM_EIGHT: begin per = 8; bits = 1; end
					FM_FOUR:  begin per = 4; bits = 2; end
					default:  begin per = 2; bits = 4; end
				endcase
				mask = (1 << bits) - 1;
				if (eos && dec_remaining > per) begin
					flag_error(eos);
					return;
				end
				for (i = 0; i < per && dec_remaining != 0; i++) begin
					idx = (b >> (8 - bits * (i + 1))) & mask;
					dec_remaining--;
					emit((idx < TBL_DEPTH) ? dec_table[idx] : 8'h00, 32'd1,
						dec_remaining == 0, 1'b0);
				end
				if (dec_remaining == 0) dec_phase = eos ? PH_FORMAT : PH_DRAIN;
			end
			default: begin
				dec_phase = eos ? PH_FORMAT : PH_DRAIN;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (report_count < MAX_REPORTS) begin
				report_count++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
					want, got);
			end
		end
	endfunction

	// Every result transaction is compared with the oldest outstanding
	// expectation. Values are read before this edge's updates land, so the
	// DUT outputs seen here are the ones the handshake actually took.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_symbols.size() == 0) begin
				mismatch_count++;
				if (report_count < MAX_REPORTS) begin
					report_count++;
					$display("%0t: unexpected result, expected none, actual %h",
						$time, result);
				end
			end else begin
				want = expected_symbols.pop_front();
				check_field("symbol", {24'd0, want.symbol}, {24'd0, result.symbol});
				check_field("repeat_count", want.repeat_count, result.repeat_count);
				check_field("last", {31'd0, want.last}, {31'd0, result.last});
				check_field("error", {31'd0, want.error}, {31'd0, result.error});
			end
		end
	end

	// The receiver switches between stall styles, from popping on every cycle
	// to long alternating stretches of stall and pop.
	always @(posedge clk) begin
		if (style_left == 0) begin
			pop_style  <= pop_style_t'($urandom_range(0, 3));
			style_left <= $urandom_range(40, 240);
		end else begin
			style_left <= style_left - 1;
		end
		case (pop_style)
			POP_ALWAYS: pop <= 1'b1;
			POP_HALF:   pop <= 1'($urandom_range(0, 1));
			POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_left == 0) begin
					pop        <= ~pop;
					stall_left <= $urandom_range(1, 24);
				end else begin
					stall_left <= stall_left - 1;
				end
			end
		endcase
	end

	// The run ends if neither side moves a transaction for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Sends one byte and updates the model at the edge that accepts it. The
	// sender works in bursts, with push low between them.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		in_item_t it;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		burst_left--;
		it.data_byte     = b;
		it.end_of_stream = eos;
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		decode_byte(it);
		items_sent++;
	endtask

	// The last byte of a stream carries end of stream.
	task automatic send_stream(input byte_q_t bytes);
		int k;
		for (k = 0; k < bytes.size(); k++) send_byte(bytes[k], k == bytes.size() - 1);
	endtask

	// Holds the sender off until every outstanding result has been popped.
	task automatic wait_for_drain();
		push <= 1'b0;
		do @(posedge clk); while (expected_symbols.size() != 0);
	endtask

	task automatic test_raw_streams();
		send_stream('{FMT_CODE_RAW, 8'h00, 8'hFF});
		// Format byte with end of stream: an empty raw stream, no result.
		send_stream('{FMT_CODE_RAW});
	endtask

	task automatic test_run_streams();
		// Largest length that fits, spread over five varint bytes.
		send_stream('{FMT_CODE_RUN, 8'hA5, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F});
	endtask

	task automatic test_packed_streams();
		// Eight per byte; index one hits an unwritten entry and reads zero.
		send_stream('{FMT_CODE_EIGHT, 8'hC3, 8'h00, 8'h0A, 8'hFF, 8'h80});
		// Two per byte across two bytes, ending half way into the second one.
		send_stream('{FMT_CODE_TWO, 8'hAB, 8'hCD, 8'h00, 8'h03, 8'h10, 8'hF0});
	endtask

	task automatic test_stream_errors();
		// Unknown format, then a byte that is only drained.
		send_stream('{8'hFF, 8'h00});
		// Length bits beyond the length register, followed by a drained byte.
		send_stream('{FMT_CODE_EIGHT, 8'h11, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80,
			8'h10, 8'h00});
		// Stream ends inside the symbol table.
		send_stream('{FMT_CODE_FOUR, 8'h33});
	endtask

	task automatic test_drain_pause();
		wait_for_drain();
	endtask

	// Mostly well-formed streams with random content; the rest is noise,
	// overflowing lengths, trailing bytes and streams cut short.
	task automatic test_random_streams(input int target);
		byte_q_t     bytes;
		logic [7:0]  code;
		logic [63:0] len;
		logic [63:0] grp;
		int          per;
		int          groups;
		int          k;
		int          n;
		while (items_sent < target) begin
			bytes = {};
			if ($urandom_range(0, 99) < 12) begin
				n = $urandom_range(1, 10);
				for (k = 0; k < n; k++)
					send_byte(8'($urandom_range(0, 255)),
						(k == n - 1) || ($urandom_range(0, 5) == 0));
			end else begin
				case ($urandom_range(0, 4))
					0:       code = FMT_CODE_RAW;
					1:       code = FMT_CODE_RUN;
					2:       code = FMT_CODE_TWO;
					3:       code = FMT_CODE_FOUR;
					default: code = FMT_CODE_EIGHT;
				endcase
				bytes.push_back(code);
				if (code == FMT_CODE_RAW) begin
					n = $urandom_range(0, 10);
					repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
				end else begin
					bytes.push_back(8'($urandom_range(0, 255)));
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18)
						: $urandom_range(0, 5);
					repeat (n) bytes.push_back(8'($urandom_range(1, 255)));
					bytes.push_back(8'h00);
					case ($urandom_range(0, 19))
						0, 1:    len = '0;
						2:       len = (code == FMT_CODE_RUN) ? {32'd0, $urandom}
							: 64'($urandom_range(60, 130));
						default: len = 64'($urandom_range(1, 24));
					endcase
					if ($urandom_range(0, 11) == 0) begin
						// Payload bits past the top of the length register.
						repeat (4) bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
						bytes.push_back(8'($urandom_range(16, 127)));
					end else begin
						groups = 1;
						while (groups < 5 && (len >> (LEN_GROUP * groups)) != 0) groups++;
						// Redundant continuation groups carrying zero payload.
						if ($urandom_range(0, 7) == 0) groups += $urandom_range(1, 5);
						for (k = 0; k < groups; k++) begin
							grp = len >> (LEN_GROUP * k);
							bytes.push_back({k < groups - 1, grp[6:0]});
						end
					end
					if (code != FMT_CODE_RUN) begin
						per = (code == FMT_CODE_EIGHT) ? 8 : (code == FMT_CODE_FOUR) ? 4 : 2;
						n = int'((len + per - 1) / per);
						repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
					end
				end
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom_range(0, 255)));
				if (bytes.size() > 2 && $urandom_range(0, 9) == 0)
					bytes = bytes[0:$urandom_range(0, bytes.size() - 2)];
				send_stream(bytes);
			end
			if ($urandom_range(0, 15) == 0) wait_for_drain();
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------

	initial begin
		int k;
		dec_phase     = PH_FORMAT;
		dec_mode      = FM_RUN;
		dec_fill      = 0;
		dec_len       = '0;
		dec_shift     = 0;
		dec_remaining = '0;
		for (k = 0; k < TBL_DEPTH; k++) dec_table[k] = 8'h00;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_raw_streams();
		test_run_streams();
		test_packed_streams();
		test_stream_errors();
		test_drain_pause();
		test_random_streams(RANDOM_ITEMS);

		// Let every owed result come out, then watch a little longer for
		// results that nobody asked for.
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> small_alphabet_unpack_decoder_unit.f
src/sau_pkg.sv
src/sau_fifo.sv
src/sau_front.sv
src/sau_back.sv
src/small_alphabet_unpack_decoder_unit.sv
tb/tb.sv
